// ===== rtl/satl_pkg.sv =====
`default_nettype none

package satl_pkg;

   localparam int unsigned ADDR_WIDTH          = 32;
   localparam int unsigned COUNT_WIDTH         = 32;
   localparam int unsigned WAYS                = 4;
   localparam int unsigned WAY_BITS            = 2;
   localparam int unsigned PLRU_BITS           = 3;
   localparam int unsigned SETS_DEFAULT        = 32;
   localparam int unsigned OFFSET_BITS_DEFAULT = 5;

   // victim way for each tree-PLRU state
   localparam logic [1:0] VICTIM_OF_STATE [8] = '{
      2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
   };

   // next PLRU state, indexed by {state, referenced way}
   localparam logic [2:0] PLRU_NEXT [32] = '{
      3'd6, 3'd4, 3'd1, 3'd0,
      3'd7, 3'd5, 3'd1, 3'd0,
      3'd6, 3'd4, 3'd3, 3'd2,
      3'd7, 3'd5, 3'd3, 3'd2,
      3'd6, 3'd4, 3'd1, 3'd0,
      3'd7, 3'd5, 3'd1, 3'd0,
      3'd6, 3'd4, 3'd3, 3'd2,
      3'd7, 3'd5, 3'd3, 3'd2
   };

   typedef struct packed {
      logic       hit;
      logic [1:0] way;
      logic       pred_ok;
   } satl_result_type;

   // floor(log2(sets)), capped at 16: number of index bits actually used
   function automatic int unsigned index_bits(input int unsigned sets);
      int unsigned bits;
      int unsigned n;
      bits = 0;
      n    = sets;
      while (n > 1 && bits < 16) begin
         n    = n >> 1;
         bits = bits + 1;
      end
      return bits;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/satl_set_ram.sv =====
`default_nettype none

module satl_set_ram #(
   parameter int unsigned ADDR_BITS = 5,
   parameter int unsigned WIDTH     = 97
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/satl_resolve.sv =====
`default_nettype none

module satl_resolve #(
   parameter  int unsigned TAG_WIDTH   = 22,
   localparam int unsigned ENTRY_WIDTH = satl_pkg::WAYS * TAG_WIDTH + satl_pkg::WAYS
                                         + satl_pkg::PLRU_BITS + satl_pkg::WAY_BITS
) (
   input  wire logic [ENTRY_WIDTH-1:0]  entry_rd,
   input  wire logic [TAG_WIDTH-1:0]    lookup_tag,
   output satl_pkg::satl_result_type    result,
   output logic      [ENTRY_WIDTH-1:0]  entry_wr
);

   localparam int unsigned VALID_LSB = satl_pkg::WAYS * TAG_WIDTH;
   localparam int unsigned PLRU_LSB  = VALID_LSB + satl_pkg::WAYS;
   localparam int unsigned PRED_LSB  = PLRU_LSB + satl_pkg::PLRU_BITS;

   logic [satl_pkg::WAYS-1:0]      valid;
   logic [satl_pkg::WAYS-1:0]      match;
   logic [satl_pkg::PLRU_BITS-1:0] plru;
   logic [satl_pkg::WAY_BITS-1:0]  pred;
   logic [satl_pkg::WAY_BITS-1:0]  pri_way;
   logic [satl_pkg::WAY_BITS-1:0]  way;
   logic                           hit;
   logic                           pred_ok;

   always_comb begin
      valid = entry_rd[VALID_LSB +: satl_pkg::WAYS];
      plru  = entry_rd[PLRU_LSB +: satl_pkg::PLRU_BITS];
      pred  = entry_rd[PRED_LSB +: satl_pkg::WAY_BITS];

      for (int w = 0; w < satl_pkg::WAYS; w++) begin
         match[w] = valid[w] && (entry_rd[w*TAG_WIDTH +: TAG_WIDTH] == lookup_tag);
      end

      // lowest matching way wins
      pri_way = '0;
      for (int w = satl_pkg::WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            pri_way = satl_pkg::WAY_BITS'(w);
         end
      end

      pred_ok = match[pred];
      hit     = |match;

      if (pred_ok) begin
         way = pred;
      end else if (hit) begin
         way = pri_way;
      end else begin
         way = satl_pkg::VICTIM_OF_STATE[plru];
      end

      entry_wr = entry_rd;
      if (!hit) begin
         entry_wr[VALID_LSB + way]            = 1'b1;
         entry_wr[way*TAG_WIDTH +: TAG_WIDTH] = lookup_tag;
      end
      entry_wr[PLRU_LSB +: satl_pkg::PLRU_BITS] = satl_pkg::PLRU_NEXT[{plru, way}];
      entry_wr[PRED_LSB +: satl_pkg::WAY_BITS]  = way;

      result.hit     = hit;
      result.way     = way;
      result.pred_ok = pred_ok;
   end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_tag_lookup_plru_waypred.sv =====
// Each accepted request reads its set from the set RAM; the set is resolved and the response registered.
// One transaction at a time: a new request is accepted only after the read-modify-write of the set RAM completes.
// A pending response holds the next lookup in place until the response is taken.
// Reset (synchronous, active high) clears counters and starts a clearing pass
// over the set RAM, one set per cycle, covering 2**floor(log2(SETS)) sets (32 by default);
// req_ready stays low until the pass is done.
`default_nettype none

module set_assoc_tag_lookup_plru_waypred #(
   parameter int unsigned SETS        = satl_pkg::SETS_DEFAULT,
   parameter int unsigned OFFSET_BITS = satl_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_address,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic [1:0]       rsp_way,
   output logic             rsp_prediction_correct,
   output logic [31:0]      rsp_hit_count,
   output logic [31:0]      rsp_miss_count,
   output logic [31:0]      rsp_predicted_hit_count
);

   // address split: | tag | index | offset |
   localparam int unsigned INDEX_BITS  = satl_pkg::index_bits(SETS);
   localparam int unsigned TAG_WIDTH   = satl_pkg::ADDR_WIDTH - OFFSET_BITS - INDEX_BITS;
   localparam int unsigned ENTRY_WIDTH = satl_pkg::WAYS * TAG_WIDTH + satl_pkg::WAYS
                                         + satl_pkg::PLRU_BITS + satl_pkg::WAY_BITS;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [INDEX_BITS-1:0]              clr_idx_ff, clr_idx_in;
   logic [INDEX_BITS-1:0]              set_ff;
   logic [TAG_WIDTH-1:0]               tag_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   satl_pkg::satl_result_type          rsp_ff;
   logic [satl_pkg::COUNT_WIDTH-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [satl_pkg::COUNT_WIDTH-1:0]   miss_cnt_ff, miss_cnt_in;
   logic [satl_pkg::COUNT_WIDTH-1:0]   pred_cnt_ff, pred_cnt_in;

   logic                               accept;
   logic                               fire;
   logic                               ram_wr_en;
   logic [INDEX_BITS-1:0]              ram_wr_addr;
   logic [ENTRY_WIDTH-1:0]             ram_wr_data;
   logic [ENTRY_WIDTH-1:0]             entry_rd;
   logic [ENTRY_WIDTH-1:0]             entry_wr;
   satl_pkg::satl_result_type          result;

   // one transaction in flight; lookup finishes once the response slot is free
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // write port: clearing pass, else write-back of the resolved set.
   // Write-back lands before the next read can be issued, so no forwarding.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = set_ff;
      ram_wr_data = entry_wr;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = '0;
      end else if (fire) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      pred_cnt_in  = pred_cnt_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (result.hit) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end else begin
            miss_cnt_in = miss_cnt_ff + 1'b1;
         end
         if (result.pred_ok) begin
            pred_cnt_in = pred_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         pred_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         pred_cnt_ff  <= pred_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= req_address[OFFSET_BITS +: INDEX_BITS];
         tag_ff <= req_address[satl_pkg::ADDR_WIDTH-1 -: TAG_WIDTH];
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   satl_set_ram #(
      .ADDR_BITS (INDEX_BITS),
      .WIDTH     (ENTRY_WIDTH)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_address[OFFSET_BITS +: INDEX_BITS]),
      .rd_data (entry_rd)
   );

   satl_resolve #(
      .TAG_WIDTH (TAG_WIDTH)
   ) u_resolve (
      .entry_rd   (entry_rd),
      .lookup_tag (tag_ff),
      .result     (result),
      .entry_wr   (entry_wr)
   );

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_hit                 = rsp_ff.hit;
   assign rsp_way                 = rsp_ff.way;
   assign rsp_prediction_correct  = rsp_ff.pred_ok;
   // counters only move on fire, when the response slot is being refilled
   assign rsp_hit_count           = hit_cnt_ff;
   assign rsp_miss_count          = miss_cnt_ff;
   assign rsp_predicted_hit_count = pred_cnt_ff;

`ifndef SYNTHESIS
   logic [satl_pkg::COUNT_WIDTH-1:0] total_cnt;
   assign total_cnt = hit_cnt_ff + miss_cnt_ff;

   // every lookup counts exactly once as hit or miss
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      fire |=> total_cnt == $past(total_cnt) + 1'b1)
      else $error("hit+miss did not advance by one");

   // a miss never bumps the predicted-hit counter
   a_miss_no_pred: assert property (@(posedge clock) disable iff (reset)
      fire && !result.hit |=> $stable(pred_cnt_ff))
      else $error("predicted-hit count moved on a miss");

   // correct prediction implies a hit
   a_pred_is_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pred_ok |-> rsp_ff.hit)
      else $error("prediction correct without hit");
`endif

endmodule

`default_nettype wire
